// File: design/kra_pkg.sv
package kra_pkg;

    localparam int unsigned KEY_CODE_W = 10;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 10;

    localparam logic [TIME_W-1:0] ARM_DELAY_MS     = 32'd300;
    localparam logic [TIME_W-1:0] REPEAT_PERIOD_MS = 32'd100;
    localparam logic [TIME_W-1:0] STALE_GAP_MS     = 32'd1000;

    localparam logic [LEVEL_W-1:0] VOLUME_CEILING_RST     = 8'd20;
    localparam logic [LEVEL_W-1:0] BRIGHTNESS_CEILING_RST = 8'd10;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [1:0] KEY_RELEASED = 2'd0;
    localparam logic [1:0] KEY_PRESSED  = 2'd1;
    localparam logic [1:0] KEY_REPEAT   = 2'd2;
    localparam logic [1:0] KEY_INVALID  = 2'd3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MODIFIER_KEY     = 3'd0,
        REG_UP_KEY           = 3'd1,
        REG_DOWN_KEY         = 3'd2,
        REG_VOLUME_FLOOR     = 3'd3,
        REG_VOLUME_CEILING   = 3'd4,
        REG_BRIGHT_FLOOR     = 3'd5,
        REG_BRIGHT_CEILING   = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic [KEY_CODE_W-1:0] modifier_key_code;
        logic [KEY_CODE_W-1:0] up_key_code;
        logic [KEY_CODE_W-1:0] down_key_code;
        logic [LEVEL_W-1:0]    volume_floor;
        logic [LEVEL_W-1:0]    volume_ceiling;
        logic [LEVEL_W-1:0]    brightness_floor;
        logic [LEVEL_W-1:0]    brightness_ceiling;
    } cfg_t;

    typedef struct packed {
        logic                  operation;
        logic [KEY_CODE_W-1:0] key_code;
        logic [1:0]            key_value;
        logic [TIME_W-1:0]     time_ms;
    } item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] volume_level;
        logic [LEVEL_W-1:0] brightness_level;
        logic               level_changed;
    } result_t;

endpackage

// File: design/kra_item_if.sv
interface kra_item_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [9:0]  key_code;
    logic [1:0]  key_value;
    logic [31:0] time_ms;

    modport source (output valid, output operation, output key_code, output key_value,
                    output time_ms, input ready);
    modport sink   (input valid, input operation, input key_code, input key_value,
                    input time_ms, output ready);
endinterface

// File: design/kra_result_if.sv
interface kra_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] volume_level;
    logic [7:0] brightness_level;
    logic       level_changed;

    modport source (output valid, output volume_level, output brightness_level,
                    output level_changed, input ready);
    modport sink   (input valid, input volume_level, input brightness_level,
                    input level_changed, output ready);
endinterface

// File: design/key_repeat_level_adjuster.sv
// Channel   Role    Payload
// -------   ------  ---------------------------------------------------
// item      sink    operation, key_code, key_value, time_ms
// result    source  volume_level, brightness_level, level_changed
// wr_*      write   wr_en, wr_index, wr_data (no read-back)
//
// Each accepted item yields exactly one result, passing through the input register and then the result register.
// One item per cycle is sustained while result is not stalled: the input register hands
// its item to the update logic and the result register in the same cycle, bounded only
// by the chained 9-bit up and 8-bit down step compares and the 32-bit time subtracts.
// Reset (rst_n, asynchronous, active low) empties both registers, clears the
// key state and levels, and loads the register defaults.
// A stall on result holds the result register; the input register then fills
// and item.ready drops until the result is taken.
module key_repeat_level_adjuster (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [kra_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [kra_pkg::CFG_DATA_W-1:0]  wr_data,
    kra_item_if.sink                        item,
    kra_result_if.source                    result
);
    import kra_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t res_comb;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;

    // The held item moves on whenever the result register is empty or is
    // being emptied by a transfer in this cycle.
    assign advance    = item_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;

    kra_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    kra_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .res     (res_comb)
    );

    // Input register: loaded on every input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            item_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg.operation <= item.operation;
            item_reg.key_code  <= item.key_code;
            item_reg.key_value <= item.key_value;
            item_reg.time_ms   <= item.time_ms;
        end
    end

    // Result register: takes the outcome of the item that advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    assign result.valid            = res_valid_reg;
    assign result.volume_level     = res_reg.volume_level;
    assign result.brightness_level = res_reg.brightness_level;
    assign result.level_changed    = res_reg.level_changed;

    // A key event never moves a level.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (item_reg.operation == OP_KEY) |=> !res_reg.level_changed)
        else $error("key event reported a level change");

    // An item that advances always lands in the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("advanced item produced no result");

    // With both registers full and the output stalled, no new item enters.
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && res_valid_reg && !result.ready |-> !item.ready)
        else $error("input accepted while the pipeline is full");

endmodule

// File: design/kra_cfg.sv
module kra_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [kra_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [kra_pkg::CFG_DATA_W-1:0]   wr_data,
    output kra_pkg::cfg_t                    cfg
);
    import kra_pkg::*;

    cfg_t cfg_reg;

    // Writes beyond the last register index fall through and are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.modifier_key_code  <= '0;
            cfg_reg.up_key_code        <= '0;
            cfg_reg.down_key_code      <= '0;
            cfg_reg.volume_floor       <= '0;
            cfg_reg.volume_ceiling     <= VOLUME_CEILING_RST;
            cfg_reg.brightness_floor   <= '0;
            cfg_reg.brightness_ceiling <= BRIGHTNESS_CEILING_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MODIFIER_KEY:   cfg_reg.modifier_key_code  <= wr_data;
                REG_UP_KEY:         cfg_reg.up_key_code        <= wr_data;
                REG_DOWN_KEY:       cfg_reg.down_key_code      <= wr_data;
                REG_VOLUME_FLOOR:   cfg_reg.volume_floor       <= wr_data[LEVEL_W-1:0];
                REG_VOLUME_CEILING: cfg_reg.volume_ceiling     <= wr_data[LEVEL_W-1:0];
                REG_BRIGHT_FLOOR:   cfg_reg.brightness_floor   <= wr_data[LEVEL_W-1:0];
                REG_BRIGHT_CEILING: cfg_reg.brightness_ceiling <= wr_data[LEVEL_W-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/kra_engine.sv
module kra_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  kra_pkg::item_t   item,
    input  kra_pkg::cfg_t    cfg,
    output kra_pkg::result_t res
);
    import kra_pkg::*;

    logic              modifier_held_reg, modifier_held_next;
    logic              up_held_reg, up_held_next;
    logic              up_pending_reg, up_pending_next;
    logic [TIME_W-1:0] up_deadline_reg, up_deadline_next;
    logic              down_held_reg, down_held_next;
    logic              down_pending_reg, down_pending_next;
    logic [TIME_W-1:0] down_deadline_reg, down_deadline_next;
    logic [LEVEL_W-1:0] volume_reg, volume_next;
    logic [LEVEL_W-1:0] brightness_reg, brightness_next;
    logic [TIME_W-1:0] prev_tick_reg, prev_tick_next;

    logic              is_tick;
    logic              key_ok;
    logic              pressed;
    logic [TIME_W-1:0] gap;
    logic              stale;
    logic [TIME_W-1:0] up_since;
    logic [TIME_W-1:0] down_since;
    logic              up_fire;
    logic              down_fire;
    logic [LEVEL_W-1:0] lvl0, lvl1, lvl2, lo, hi;
    logic [LEVEL_W:0]   up_inc;
    logic [LEVEL_W-1:0] down_dec;
    logic              up_ok;
    logic              down_ok;

    assign is_tick    = (item.operation == OP_TICK);
    assign key_ok     = (item.key_value != KEY_INVALID);
    assign pressed    = (item.key_value != KEY_RELEASED);
    assign gap        = item.time_ms - prev_tick_reg;
    assign stale      = (gap > STALE_GAP_MS);
    assign up_since   = item.time_ms - up_deadline_reg;
    assign down_since = item.time_ms - down_deadline_reg;

    // A deadline counts as reached when the wrapped difference is non-negative.
    assign up_fire   = is_tick && !stale &&
                       (up_pending_reg || (up_held_reg && !up_since[TIME_W-1]));
    assign down_fire = is_tick && !stale &&
                       (down_pending_reg || (down_held_reg && !down_since[TIME_W-1]));

    assign lvl0 = modifier_held_reg ? brightness_reg : volume_reg;
    assign lo   = modifier_held_reg ? cfg.brightness_floor : cfg.volume_floor;
    assign hi   = modifier_held_reg ? cfg.brightness_ceiling : cfg.volume_ceiling;

    // Up is applied first; the down step then starts from its outcome.
    assign up_inc = {1'b0, lvl0} + {{LEVEL_W{1'b0}}, 1'b1};
    assign up_ok  = up_fire && (up_inc >= {1'b0, lo}) && (up_inc <= {1'b0, hi});
    assign lvl1   = up_ok ? up_inc[LEVEL_W-1:0] : lvl0;

    assign down_dec = lvl1 - {{(LEVEL_W-1){1'b0}}, 1'b1};
    assign down_ok  = down_fire && (lvl1 != '0) && (down_dec >= lo) && (down_dec <= hi);
    assign lvl2     = down_ok ? down_dec : lvl1;

    always_comb
    begin
        modifier_held_next = modifier_held_reg;
        up_held_next       = up_held_reg;
        up_pending_next    = up_pending_reg;
        up_deadline_next   = up_deadline_reg;
        down_held_next     = down_held_reg;
        down_pending_next  = down_pending_reg;
        down_deadline_next = down_deadline_reg;
        volume_next        = volume_reg;
        brightness_next    = brightness_reg;
        prev_tick_next     = prev_tick_reg;

        if (!is_tick)
        begin
            if (key_ok)
            begin
                if (item.key_code == cfg.modifier_key_code)
                begin
                    modifier_held_next = pressed;
                end
                else if (item.key_code == cfg.up_key_code)
                begin
                    up_held_next    = pressed;
                    up_pending_next = pressed;
                    if (pressed)
                    begin
                        up_deadline_next = item.time_ms + ARM_DELAY_MS;
                    end
                end
                else if (item.key_code == cfg.down_key_code)
                begin
                    down_held_next    = pressed;
                    down_pending_next = pressed;
                    if (pressed)
                    begin
                        down_deadline_next = item.time_ms + ARM_DELAY_MS;
                    end
                end
            end
        end
        else
        begin
            prev_tick_next = item.time_ms;
            if (stale)
            begin
                modifier_held_next = 1'b0;
                up_held_next       = 1'b0;
                up_pending_next    = 1'b0;
                up_deadline_next   = '0;
                down_held_next     = 1'b0;
                down_pending_next  = 1'b0;
                down_deadline_next = '0;
            end
            else
            begin
                if (up_fire)
                begin
                    if (up_pending_reg)
                    begin
                        up_pending_next = 1'b0;
                    end
                    else
                    begin
                        up_deadline_next = up_deadline_reg + REPEAT_PERIOD_MS;
                    end
                end
                if (down_fire)
                begin
                    if (down_pending_reg)
                    begin
                        down_pending_next = 1'b0;
                    end
                    else
                    begin
                        down_deadline_next = down_deadline_reg + REPEAT_PERIOD_MS;
                    end
                end
                if (modifier_held_reg)
                begin
                    brightness_next = lvl2;
                end
                else
                begin
                    volume_next = lvl2;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modifier_held_reg <= 1'b0;
            up_held_reg       <= 1'b0;
            up_pending_reg    <= 1'b0;
            up_deadline_reg   <= '0;
            down_held_reg     <= 1'b0;
            down_pending_reg  <= 1'b0;
            down_deadline_reg <= '0;
            volume_reg        <= '0;
            brightness_reg    <= '0;
            prev_tick_reg     <= '0;
        end
        else if (advance)
        begin
            modifier_held_reg <= modifier_held_next;
            up_held_reg       <= up_held_next;
            up_pending_reg    <= up_pending_next;
            up_deadline_reg   <= up_deadline_next;
            down_held_reg     <= down_held_next;
            down_pending_reg  <= down_pending_next;
            down_deadline_reg <= down_deadline_next;
            volume_reg        <= volume_next;
            brightness_reg    <= brightness_next;
            prev_tick_reg     <= prev_tick_next;
        end
    end

    assign res.volume_level     = volume_next;
    assign res.brightness_level = brightness_next;
    assign res.level_changed    = up_ok || down_ok;

endmodule
